### design/keypad_code_lock_controller_macros.svh
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// Concurrent check on the rising clock edge, idle while reset is asserted
`define KCLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication check: when the trigger holds, the consequence holds in the same cycle
`define KCLC_ASSERT_IMPL(label, trig, cons, msg) \
  `KCLC_ASSERT(label, (trig) |-> (cons), msg)

`endif

### design/kclc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kclc_pkg;

  // Decoded key codes with a meaning of their own
  localparam logic [3:0] KEY_NONE = 4'd0;
  localparam logic [3:0] KEY_HASH = 4'd1;
  localparam logic [3:0] KEY_STAR = 4'd3;

  // Change sequence after reset: four presses of key code 2 (0x2222)
  localparam logic [15:0] SEQ_RESET = 16'd8738;

  // First digit of the code after reset; later digits count down, repeating every four
  localparam int unsigned CODE_RESET_TOP = 12;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_CONFIRM = 2'd1,
    MODE_NEW     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MOTOR_NONE   = 2'd0,
    MOTOR_UNLOCK = 2'd1,
    MOTOR_LOCK   = 2'd2
  } motor_e;

  // One result word, digit_leds in the lowest bits
  typedef struct packed {
    mode_e      entry_mode;
    motor_e     motor_move;
    logic       light_on;
    logic       locked;
    logic [3:0] digit_leds;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // Light the lowest count LEDs, all four from four up
  function automatic logic [3:0] low_leds(input int unsigned count);
    logic [3:0] leds;
    if (count >= 4) begin
      leds = 4'hF;
    end else begin
      leds = 4'((5'd1 << count) - 5'd1);
    end
    return leds;
  endfunction

  // Stored code digit at position idx after reset
  function automatic logic [3:0] reset_digit(input int unsigned idx);
    return 4'(CODE_RESET_TOP - (idx % 4));
  endfunction

endpackage

`default_nettype wire

### design/kclc_core.sv
`timescale 1ns / 1ps
`default_nettype none

module kclc_core #(
  parameter int CODE_LENGTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [3:0]       key_i,
  input  wire logic             cfg_we_i,
  input  wire logic [15:0]      cfg_data_i,
  output kclc_pkg::result_t     result_o
);

  localparam int PosW = $clog2(CODE_LENGTH);

  logic [PosW-1:0]     pos_q, pos_d;
  logic [3:0]          entered_q [CODE_LENGTH];
  logic [3:0]          entered_d [CODE_LENGTH];
  logic [3:0]          entered_wr [CODE_LENGTH];
  logic [3:0]          stored_q [CODE_LENGTH];
  logic [3:0]          stored_d [CODE_LENGTH];
  logic                lock_q, lock_d;
  logic                light_q, light_d;
  kclc_pkg::mode_e     mode_q, mode_d;
  logic [3:0]          led_q, led_d;
  logic [15:0]         seq_q;
  kclc_pkg::motor_e    motor;
  logic                last_digit;
  logic                match_stored;
  logic                match_seq;

  // Entry with the current key placed at the cursor, compared in parallel
  always_comb begin
    entered_wr = entered_q;
    entered_wr[pos_q] = key_i;
    match_stored = 1'b1;
    match_seq = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entered_wr[i] != stored_q[i]) begin
        match_stored = 1'b0;
      end
      if (entered_wr[i] != 4'(seq_q >> ((CODE_LENGTH - 1 - i) * 4))) begin
        match_seq = 1'b0;
      end
    end
  end

  assign last_digit = (pos_q == PosW'(CODE_LENGTH - 1));

  // Next state for one key
  always_comb begin
    pos_d     = pos_q;
    entered_d = entered_q;
    stored_d  = stored_q;
    lock_d    = lock_q;
    light_d   = light_q;
    mode_d    = mode_q;
    led_d     = led_q;
    motor     = kclc_pkg::MOTOR_NONE;
    if (step_i && key_i != kclc_pkg::KEY_NONE) begin
      unique case (mode_q) inside
        kclc_pkg::MODE_CONFIRM, kclc_pkg::MODE_NEW: begin
          // Every key is a digit while changing the code
          if (mode_q == kclc_pkg::MODE_CONFIRM) begin
            entered_d[pos_q] = key_i;
          end else begin
            stored_d[pos_q] = key_i;
          end
          if (last_digit) begin
            pos_d = '0;
            if (mode_q == kclc_pkg::MODE_CONFIRM && match_stored) begin
              mode_d = kclc_pkg::MODE_NEW;
              led_d  = kclc_pkg::low_leds(CODE_LENGTH);
            end else begin
              mode_d = kclc_pkg::MODE_NORMAL;
              led_d  = '0;
            end
          end else begin
            pos_d = pos_q + PosW'(1);
            led_d = kclc_pkg::low_leds(32'(CODE_LENGTH - 1 - int'(pos_q)));
          end
        end
        default: begin
          if (key_i == kclc_pkg::KEY_STAR) begin
            pos_d = '0;
            led_d = '0;
          end else if (key_i == kclc_pkg::KEY_HASH) begin
            pos_d   = '0;
            light_d = ~light_q;
            led_d   = '0;
          end else begin
            entered_d[pos_q] = key_i;
            led_d = led_q | (4'b0001 << pos_q);
            if (last_digit) begin
              pos_d = '0;
              if (match_stored) begin
                // Open toggles to locked and back
                motor  = lock_q ? kclc_pkg::MOTOR_UNLOCK : kclc_pkg::MOTOR_LOCK;
                lock_d = ~lock_q;
                led_d  = '0;
              end else if (match_seq) begin
                mode_d = kclc_pkg::MODE_CONFIRM;
                led_d  = kclc_pkg::low_leds(CODE_LENGTH);
              end else begin
                led_d = '0;
              end
            end else begin
              pos_d = pos_q + PosW'(1);
            end
          end
        end
      endcase
    end
  end

  // Result after the update
  always_comb begin
    result_o.digit_leds = led_d;
    result_o.locked     = lock_d;
    result_o.light_on   = light_d;
    result_o.motor_move = motor;
    result_o.entry_mode = mode_d;
  end

  // Control state and stored code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      lock_q  <= 1'b1;
      light_q <= 1'b0;
      mode_q  <= kclc_pkg::MODE_NORMAL;
      led_q   <= '0;
      seq_q   <= kclc_pkg::SEQ_RESET;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_q[i] <= kclc_pkg::reset_digit(i);
      end
    end else begin
      pos_q    <= pos_d;
      lock_q   <= lock_d;
      light_q  <= light_d;
      mode_q   <= mode_d;
      led_q    <= led_d;
      stored_q <= stored_d;
      if (cfg_we_i) begin
        seq_q <= cfg_data_i;
      end
    end
  end

  // Entered digits hold whatever was keyed last
  always_ff @(posedge clk_i) begin
    entered_q <= entered_d;
  end

endmodule

`default_nettype wire

### design/keypad_code_lock_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// A key word is held in the input register; its result word is computed from it and
// captured in the result register, from which the receiver takes it.
// Throughput: one key word per cycle; the input register and the result register
// advance together, so the input side stalls only while a result waits unread.
// Reset (rst_ni low, asynchronous): locked, light off, normal entry, LEDs off,
// code 12,11,10,9 and change sequence 0x2222; the pipeline empties.

module keypad_code_lock_controller #(
  parameter int CODE_LENGTH = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] key_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] digit_leds, [4] locked, [5] light_on, [7:6] motor_move, [9:8] entry_mode
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  logic              in_valid_q;
  logic [3:0]        key_q;
  logic              out_valid_q;
  kclc_pkg::result_t out_q;
  kclc_pkg::result_t result;
  logic              advance;

  // Move a word from the input register to the result register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  kclc_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .key_i      (key_q),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result)
  );

  // Hold valid flags of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture key and result payloads
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_q <= s_axis_tdata[3:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(16 - kclc_pkg::RESULT_W)'(0), out_q};

endmodule

`default_nettype wire

### design/kclc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_code_lock_controller_macros.svh"

module kclc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  logic [1:0] motor;
  logic [1:0] mode;

  assign motor = m_axis_tdata[7:6];
  assign mode  = m_axis_tdata[9:8];

  // Stalled result word stays put
  `KCLC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  // Input stalls only behind a waiting result
  `KCLC_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without a blocked result")

  // A motor turn leaves the lock in the state it turned to
  `KCLC_ASSERT_IMPL(a_motor_lock, m_axis_tvalid && motor != kclc_pkg::MOTOR_NONE, (motor == kclc_pkg::MOTOR_UNLOCK && !m_axis_tdata[4]) || (motor == kclc_pkg::MOTOR_LOCK && m_axis_tdata[4]), "motor command disagrees with lock state")

  // A motor turn only in normal entry, with the cursor LEDs cleared
  `KCLC_ASSERT_IMPL(a_motor_mode, m_axis_tvalid && motor != kclc_pkg::MOTOR_NONE, mode == kclc_pkg::MODE_NORMAL && m_axis_tdata[3:0] == 4'h0, "motor turn outside normal entry")

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (.*);

`default_nettype wire
